[rtl/core/mpfr_pkg.sv]
package mpfr_pkg;

  localparam int unsigned DEF_COLUMNS = 128;
  localparam int unsigned DEF_ROWS    = 32;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAGE_ROWS   = 8;
  // Each page is preceded by four command bytes.
  localparam int unsigned CMD_BYTES   = 4;

  localparam logic [BYTE_W-1:0] PAGE_ADDR_CMD = 8'h22;
  localparam logic [BYTE_W-1:0] COL_LOW_CMD   = 8'h00;
  localparam logic [BYTE_W-1:0] COL_HIGH_CMD  = 8'h10;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_START = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] x;
    logic [4:0] y;
    logic       value;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic              pixel;
    logic [BYTE_W-1:0] out_byte;
    logic              is_command;
    logic              last;
  } out_item_t;

  // Where the refresh scan stands: the byte that the next tick sends.
  typedef struct packed {
    logic              active;
    logic              is_cmd;
    logic [BYTE_W-1:0] cmd_byte;
    logic              last;
  } scan_t;

endpackage

[rtl/core/mpfr_store.sv]
module mpfr_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);
  import mpfr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled result can wait on it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mpfr_scan.sv]
module mpfr_scan #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned ROWS    = 32,
  parameter int unsigned ADDR_W  = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                advance_i,
  output mpfr_pkg::scan_t     scan_o,
  output logic [ADDR_W-1:0]   data_addr_o
);
  import mpfr_pkg::*;

  localparam int unsigned PAGES      = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned LINE_BYTES = COLUMNS + CMD_BYTES;
  localparam int unsigned OFF_W      = $clog2(LINE_BYTES);

  logic              active_q;
  logic [PAGE_W-1:0] page_q;
  logic [OFF_W-1:0]  off_q;
  logic [ADDR_W-1:0] addr_q;
  logic              is_cmd;
  logic              line_end;
  logic              frame_end;
  logic [BYTE_W-1:0] cmd_byte;

  assign is_cmd    = (off_q < OFF_W'(CMD_BYTES));
  assign line_end  = (off_q == OFF_W'(LINE_BYTES - 1));
  assign frame_end = line_end && (page_q == PAGE_W'(PAGES - 1));

  always_comb begin
    case (off_q[1:0])
      2'd0:    cmd_byte = PAGE_ADDR_CMD;
      2'd1:    cmd_byte = BYTE_W'(page_q);
      2'd2:    cmd_byte = COL_LOW_CMD;
      default: cmd_byte = COL_HIGH_CMD;
    endcase
  end

  // The data address runs on across pages, since pages are stored back to back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      page_q   <= '0;
      off_q    <= '0;
      addr_q   <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      page_q   <= '0;
      off_q    <= '0;
      addr_q   <= '0;
    end else if (advance_i && active_q) begin
      if (frame_end) begin
        active_q <= 1'b0;
        page_q   <= '0;
        off_q    <= '0;
        addr_q   <= '0;
      end else begin
        if (line_end) begin
          off_q  <= '0;
          page_q <= page_q + PAGE_W'(1);
        end else begin
          off_q <= off_q + OFF_W'(1);
        end
        if (!is_cmd) begin
          addr_q <= addr_q + ADDR_W'(1);
        end
      end
    end
  end

  assign scan_o.active   = active_q;
  assign scan_o.is_cmd   = is_cmd;
  assign scan_o.cmd_byte = cmd_byte;
  assign scan_o.last     = frame_end;
  assign data_addr_o     = addr_q;

endmodule

[rtl/core/mono_page_framebuffer_refresh.sv]
// Page framebuffer for a monochrome display of COLUMNS x ROWS pixels, packed as
// pages of eight rows, one byte per column and page, top row in bit 0, held in a
// single-port-write, registered-read RAM. A pixel write reads the byte, then
// writes it back modified; a pixel read or a tick during a refresh passes
// through the response state, which waits for the output register to drain;
// start refresh, ignored codes and ticks while no refresh runs are handled
// without leaving idle. A clear sweeps the RAM one byte a cycle; the same sweep
// runs after reset, and no item is accepted until it has finished. Each tick of
// a refresh returns the next byte of the frame: per page the commands 0x22,
// page, 0x00, 0x10 and then COLUMNS data bytes, the final byte flagged last.
module mono_page_framebuffer_refresh #(
  parameter int unsigned COLUMNS = mpfr_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = mpfr_pkg::DEF_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mpfr_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mpfr_pkg::out_item_t  out_o
);
  import mpfr_pkg::*;

  localparam int unsigned PAGES  = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned DEPTH  = PAGES * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic [ADDR_W-1:0] wr_addr_q;
  logic [2:0]        bit_q;
  logic              value_q;
  logic              kind_q;
  logic              inrange_q;
  logic              iscmd_q;
  logic [BYTE_W-1:0] cbyte_q;
  logic              last_q;

  logic              out_valid_q;
  out_item_t         out_q, out_d;

  logic              in_take;
  logic              out_free;
  logic              out_load;
  logic              in_range;
  logic [ADDR_W-1:0] pix_addr;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] bit_mask;

  logic              scan_start;
  logic              scan_advance;
  scan_t             scan;
  logic [ADDR_W-1:0] scan_addr;

  mpfr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mpfr_scan #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .advance_i   (scan_advance),
    .scan_o      (scan),
    .data_addr_o (scan_addr)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_range = (int'(in_i.x) < COLUMNS) && (int'(in_i.y) < ROWS);
  assign pix_addr = ADDR_W'(int'(in_i.y[4:3]) * COLUMNS + int'(in_i.x));
  assign bit_mask = BYTE_W'(1) << bit_q;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    we           = 1'b0;
    waddr        = wr_addr_q;
    wdata        = '0;
    rd_en        = 1'b0;
    rd_addr      = pix_addr;
    scan_start   = 1'b0;
    scan_advance = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          case (in_i.cmd)
            CMD_WRITE: begin
              if (in_range) begin
                rd_en   = 1'b1;
                state_d = ST_MOD;
              end
            end
            CMD_READ: begin
              rd_en   = 1'b1;
              state_d = ST_RESP;
            end
            CMD_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            CMD_START: begin
              scan_start = 1'b1;
            end
            CMD_TICK: begin
              if (scan.active) begin
                scan_advance = 1'b1;
                rd_en        = !scan.is_cmd;
                rd_addr      = scan_addr;
                state_d      = ST_RESP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        we      = 1'b1;
        wdata   = value_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        state_d = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.kind = kind_q;
    if (kind_q == KIND_READ) begin
      out_d.pixel      = inrange_q & rd_data[bit_q];
      out_d.out_byte   = '0;
      out_d.is_command = 1'b0;
      out_d.last       = 1'b0;
    end else begin
      out_d.pixel      = 1'b0;
      out_d.out_byte   = iscmd_q ? cbyte_q : rd_data;
      out_d.is_command = iscmd_q;
      out_d.last       = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      wr_addr_q <= pix_addr;
      bit_q     <= in_i.y[2:0];
      value_q   <= in_i.value;
      kind_q    <= (in_i.cmd == CMD_TICK) ? KIND_BYTE : KIND_READ;
      inrange_q <= in_range;
      iscmd_q   <= scan.is_cmd;
      cbyte_q   <= scan.cmd_byte;
      last_q    <= scan.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_CLEAR || state_q == ST_MOD))
    else $error("store written outside clear or write-back");

  a_write_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_i.cmd == CMD_WRITE && in_range) |=> (state_q == ST_MOD))
    else $error("pixel write did not enter write-back");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("result appeared without a response phase");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan.active && scan.last) |-> !scan.is_cmd)
    else $error("frame ends on a command byte");

endmodule

[tb/mono_page_framebuffer_refresh_tb.sv]
`timescale 1ns / 1ps

module mono_page_framebuffer_refresh_tb;
  import mpfr_pkg::*;

  localparam int unsigned COLS        = DEF_COLUMNS;
  localparam int unsigned ROW_CNT     = DEF_ROWS;
  localparam int unsigned PAGES       = (ROW_CNT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned PAGE_BYTES  = COLS + CMD_BYTES;
  localparam int unsigned FRAME_BYTES = PAGES * PAGE_BYTES;
  localparam int unsigned STORE_DEPTH = PAGES * COLS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 600;
  localparam int unsigned HOLD_LEN    = 400;

  // Command codes the block ignores.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_o;

  mono_page_framebuffer_refresh u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_o       (out_o)
  );

  // Mirror of the pixel store and the refresh scan.
  logic [7:0]  fb_mem [STORE_DEPTH];
  int unsigned scan_pos;
  bit          scan_on;

  out_item_t   answers_q [$];
  int unsigned fails     = 0;
  int unsigned got_count = 0;
  int unsigned cycles    = 0;
  bit          calm      = 1'b0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } probe_t;

  probe_t probes [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted command to the mirror; returns 1 when it yields an answer.
  function automatic bit framebuffer_cmd(input in_item_t it, output out_item_t ans);
    int unsigned addr;
    int unsigned page;
    int unsigned off;
    addr = (int'(it.y) / PAGE_ROWS) * COLS + int'(it.x);
    ans  = '0;
    case (it.cmd)
      CMD_WRITE: begin
        fb_mem[addr][it.y[2:0]] = it.value;
        return 1'b0;
      end
      CMD_READ: begin
        ans.kind  = KIND_READ;
        ans.pixel = fb_mem[addr][it.y[2:0]];
        return 1'b1;
      end
      CMD_CLEAR: begin
        foreach (fb_mem[i]) fb_mem[i] = '0;
        return 1'b0;
      end
      CMD_START: begin
        scan_pos = 0;
        scan_on  = 1'b1;
        return 1'b0;
      end
      CMD_TICK: begin
        if (!scan_on) return 1'b0;
        if (scan_pos >= FRAME_BYTES) scan_pos = 0;
        page           = scan_pos / PAGE_BYTES;
        off            = scan_pos % PAGE_BYTES;
        ans.kind       = KIND_BYTE;
        ans.is_command = 1'b1;
        case (off)
          0: ans.out_byte = PAGE_ADDR_CMD;
          1: ans.out_byte = page[7:0];
          2: ans.out_byte = COL_LOW_CMD;
          3: ans.out_byte = COL_HIGH_CMD;
          default: begin
            ans.out_byte   = fb_mem[page * COLS + off - CMD_BYTES];
            ans.is_command = 1'b0;
          end
        endcase
        if (scan_pos + 1 >= FRAME_BYTES) begin
          ans.last = 1'b1;
          scan_on  = 1'b0;
          scan_pos = 0;
        end else begin
          scan_pos++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly zero, sometimes a few cycles, rarely a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t any_pixel(input logic [2:0] cmd);
    in_item_t it;
    it.cmd   = cmd;
    it.x     = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 7'(COLS - 1) : 7'd0)
                                           : 7'($urandom_range(0, COLS - 1));
    it.y     = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 5'(ROW_CNT - 1) : 5'd0)
                                           : 5'($urandom_range(0, ROW_CNT - 1));
    it.value = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [2:0] spare_cmd();
    case ($urandom_range(0, 2))
      0:       return CMD_SPARE_A;
      1:       return CMD_SPARE_B;
      default: return CMD_SPARE_C;
    endcase
  endfunction

  function automatic out_item_t cmd_byte(input logic [7:0] b);
    return out_item_t'{KIND_BYTE, 1'b0, b, 1'b1, 1'b0};
  endfunction

  function automatic void add_probe(input logic [2:0] cmd, input int unsigned x,
                                    input int unsigned y, input bit v,
                                    input bit typed, input out_item_t want);
    probe_t p;
    p.item  = in_item_t'{cmd, 7'(x), 5'(y), v};
    p.typed = typed;
    p.want  = want;
    probes.push_back(p);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   ans;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    if (framebuffer_cmd(it, ans)) answers_q.push_back(typed ? want : ans);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_q.size() != 0) @(posedge clk);
  endtask

  // Result side: check every accepted result, stall at random.
  initial begin
    int unsigned stall_run;
    int unsigned hold_left;
    int unsigned last_hold_at;
    out_item_t   exp_ans;
    stall_run    = 0;
    hold_left    = 0;
    last_hold_at = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid_o && !out_stall) begin
        if (answers_q.size() == 0) begin
          $error("unexpected result: %h", out_o);
          fails++;
        end else begin
          exp_ans = answers_q.pop_front();
          if (out_o.kind !== exp_ans.kind) begin
            $error("kind: expected %0d, got %0d", exp_ans.kind, out_o.kind);
            fails++;
          end
          if (out_o.pixel !== exp_ans.pixel) begin
            $error("pixel: expected %0d, got %0d", exp_ans.pixel, out_o.pixel);
            fails++;
          end
          if (out_o.out_byte !== exp_ans.out_byte) begin
            $error("out_byte: expected %h, got %h", exp_ans.out_byte, out_o.out_byte);
            fails++;
          end
          if (out_o.is_command !== exp_ans.is_command) begin
            $error("is_command: expected %0d, got %0d", exp_ans.is_command,
                   out_o.is_command);
            fails++;
          end
          if (out_o.last !== exp_ans.last) begin
            $error("last: expected %0d, got %0d", exp_ans.last, out_o.last);
            fails++;
          end
        end
        got_count++;
      end
      // Two long hold-offs: one among pixel reads, one in the middle of a frame.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ((got_count == 30 || got_count == 400) && got_count != last_hold_at) begin
        last_hold_at = got_count;
        hold_left    = HOLD_LEN - 1;
        out_stall   <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_run = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_item_t   none;
    out_item_t   rd0;
    out_item_t   rd1;
    int unsigned r;
    int unsigned n;
    none = '0;
    rd0  = out_item_t'{KIND_READ, 1'b0, 8'h00, 1'b0, 1'b0};
    rd1  = out_item_t'{KIND_READ, 1'b1, 8'h00, 1'b0, 1'b0};
    foreach (fb_mem[i]) fb_mem[i] = '0;
    scan_pos = 0;
    scan_on  = 1'b0;

    // Corners of the store, ignored codes, the frame header, restart and clear mid-frame.
    add_probe(CMD_READ,  0,        0,           0, 1, rd0);
    add_probe(CMD_READ,  COLS - 1, ROW_CNT - 1, 0, 1, rd0);
    add_probe(CMD_WRITE, COLS - 1, ROW_CNT - 1, 1, 0, none);
    add_probe(CMD_READ,  COLS - 1, ROW_CNT - 1, 0, 1, rd1);
    add_probe(CMD_WRITE, 0,        0,           1, 0, none);
    add_probe(CMD_WRITE, 0,        7,           1, 0, none);
    add_probe(CMD_READ,  0,        7,           0, 0, none);
    add_probe(CMD_WRITE, 0,        0,           0, 0, none);
    add_probe(CMD_READ,  0,        0,           0, 1, rd0);
    add_probe(CMD_TICK,  0,        0,           0, 0, none);
    add_probe(CMD_SPARE_A, COLS - 1, ROW_CNT - 1, 1, 0, none);
    add_probe(CMD_SPARE_B, 0,        0,           1, 0, none);
    add_probe(CMD_SPARE_C, COLS - 1, 0,           0, 0, none);
    add_probe(CMD_START, 0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 1, cmd_byte(PAGE_ADDR_CMD));
    add_probe(CMD_TICK,  0, 0, 0, 1, cmd_byte(8'd0));
    add_probe(CMD_TICK,  0, 0, 0, 1, cmd_byte(COL_LOW_CMD));
    add_probe(CMD_TICK,  0, 0, 0, 1, cmd_byte(COL_HIGH_CMD));
    add_probe(CMD_TICK,  0, 0, 0, 0, none);
    add_probe(CMD_START, 0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 1, cmd_byte(PAGE_ADDR_CMD));
    add_probe(CMD_CLEAR, 0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 0, none);
    add_probe(CMD_TICK,  0, 0, 0, 0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) send_item(probes[i].item, probes[i].typed, probes[i].want);
    wait_drained();

    // Pixel traffic; the first long hold-off lands here.
    for (n = 0; n < 150; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      send_item(any_pixel(CMD_WRITE), 0, none);
      else if (r < 96) send_item(any_pixel(CMD_READ), 0, none);
      else if (r < 98) send_item(any_pixel(CMD_CLEAR), 0, none);
      else             send_item(any_pixel(spare_cmd()), 0, none);
    end
    wait_drained();

    // One whole frame, with pixel traffic woven in, up to its last byte.
    send_item(any_pixel(CMD_START), 0, none);
    while (scan_on) begin
      r = $urandom_range(0, 99);
      if (r < 85)      send_item(any_pixel(CMD_TICK), 0, none);
      else if (r < 91) send_item(any_pixel(CMD_WRITE), 0, none);
      else if (r < 96) send_item(any_pixel(CMD_READ), 0, none);
      else if (r < 97) send_item(any_pixel(CMD_CLEAR), 0, none);
      else             send_item(any_pixel(spare_cmd()), 0, none);
    end
    wait_drained();

    // Free mix: restarts, idle ticks, clears and noise.
    for (n = 0; n < 100; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      send_item(any_pixel(CMD_TICK), 0, none);
      else if (r < 50) send_item(any_pixel(CMD_WRITE), 0, none);
      else if (r < 70) send_item(any_pixel(CMD_READ), 0, none);
      else if (r < 76) send_item(any_pixel(CMD_START), 0, none);
      else if (r < 79) send_item(any_pixel(CMD_CLEAR), 0, none);
      else             send_item(any_pixel(spare_cmd()), 0, none);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0 && answers_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mpfr_pkg.sv
rtl/core/mpfr_store.sv
rtl/core/mpfr_scan.sv
rtl/core/mono_page_framebuffer_refresh.sv
tb/mono_page_framebuffer_refresh_tb.sv
